// File: rtl/cbba_pkg.sv
// Shared types and constants for the contiguous bitmap block allocator.
// No dependencies; imported by cbba_layout and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cbba_pkg;

  localparam int MAX_BLOCKS      = 4096;
  localparam int ROOT_DIR_BLOCKS = 4;
  localparam int MIN_VOLUME      = 8;
  localparam int MIN_BLOCK_BYTES = 64;

  localparam int REG_W   = 13;                       // config register width
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);   // block counts
  localparam int BLK_W   = $clog2(MAX_BLOCKS);       // block index

  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
  localparam int ADDR_W     = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CHUNK_BITS = 8;
  localparam int CHUNKS     = WORD_BITS / CHUNK_BITS;
  localparam int CHUNK_W    = $clog2(CHUNKS);
  localparam int SUB_W      = $clog2(CHUNK_BITS);

  localparam int MAPB_W = $clog2(MAX_BLOCKS / 8 + 1);                      // map bytes
  localparam int ACC_W  = REG_W + 1;
  localparam int MBLK_W = $clog2(MAX_BLOCKS / 8 / MIN_BLOCK_BYTES + 2);    // map blocks

  localparam logic REG_VOLUME = 1'b0;
  localparam logic REG_BLOCK  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_UNFORMATTED = 2'd1,
    STAT_NO_RUN      = 2'd2,
    STAT_TOO_SMALL   = 2'd3
  } status_t;

  typedef enum logic {
    OP_FORMAT = 1'b0,
    OP_ALLOC  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FMT_CALC,
    ST_FMT_FILL,
    ST_RD,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             done;
    logic             fits;
    logic [CNT_W-1:0] first_blk;
    logic [CNT_W-1:0] vol;
  } layout_t;

endpackage

`default_nettype wire

// File: rtl/cbba_layout.sv
// Format layout unit: clamps the volume, divides map bytes by block size
// by repeated addition and reports the first data block. Uses cbba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbba_layout
  import cbba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [REG_W-1:0] volume_blocks,
  input  wire logic [REG_W-1:0] block_bytes,
  output layout_t               layout
);

  logic              busy;
  logic              bad;
  logic [ACC_W-1:0]  acc;
  logic [MBLK_W-1:0] mblk;
  logic [MAPB_W-1:0] map_bytes;
  logic [CNT_W-1:0]  vol;
  logic [CNT_W-1:0]  vol_clamp;
  logic [CNT_W:0]    vol_round;
  logic              div_done;

  assign vol_clamp = (volume_blocks > REG_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                          : CNT_W'(volume_blocks);
  assign vol_round = {1'b0, vol_clamp} + (CNT_W + 1)'(7);
  assign div_done  = busy && (bad || (acc >= ACC_W'(map_bytes)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (div_done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bad       <= (volume_blocks < REG_W'(MIN_VOLUME)) ||
                   (block_bytes < REG_W'(MIN_BLOCK_BYTES));
      acc       <= '0;
      mblk      <= '0;
      map_bytes <= MAPB_W'(vol_round >> 3);
      vol       <= vol_clamp;
    end else if (busy && !div_done) begin
      acc  <= acc + ACC_W'(block_bytes);
      mblk <= mblk + MBLK_W'(1);
    end
  end

  always_comb begin
    layout.done      = div_done;
    layout.first_blk = CNT_W'(mblk) + CNT_W'(1 + ROOT_DIR_BLOCKS);
    layout.fits      = !bad && (layout.first_blk <= vol);
    layout.vol       = vol;
  end

endmodule

`default_nettype wire

// File: rtl/contiguous_bitmap_block_allocator.sv
// Contiguous bitmap block allocator, top level. Uses cbba_pkg and cbba_layout.
// The usage map lives in a 64 x 64-bit synchronous RAM inside this module.
//
// One word in, one word out. A format runs the layout divide and then rewrites
// the map one word at a time. An allocate is paced by the map RAM read port
// and the first-fit scan, which checks eight bits per cycle: each map word is
// read, then scanned chunk by chunk, and the map words the found run touches
// are each read and rewritten to mark it used. Refused allocates skip the
// scan and go straight to the result. The map is not readable before the
// first format, which rewrites every word, so no clearing pass follows reset.
// Register writes take effect at the next format.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_bitmap_block_allocator
  import cbba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [12:0] run_length
  input  wire logic [0:0]  s_tuser,   // [0] op
  // result words
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [1:0] status, [13:2] start_block,
                                      // [26:14] free_blocks, [39:27] first_data_block
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  state_t state, state_next;

  logic [REG_W-1:0] volume_blocks;
  logic [REG_W-1:0] block_bytes;

  logic             formatted;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] data_start;

  logic [CNT_W-1:0]   count;
  logic [ADDR_W-1:0]  w_addr;
  logic [CHUNK_W-1:0] chunk;
  logic [CNT_W-1:0]   run;
  logic [BLK_W-1:0]   run_start;
  logic [BLK_W-1:0]   run_end;
  status_t            res_status;
  logic [BLK_W-1:0]   res_start;

  status_t            out_status;
  logic [BLK_W-1:0]   out_start;
  logic [CNT_W-1:0]   out_free;
  logic [CNT_W-1:0]   out_first;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_word;
  logic                 mem_re;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] fill_word;
  logic [WORD_BITS-1:0] mark_mask;

  logic             scan_hit;
  logic [CNT_W-1:0] scan_run;
  logic [BLK_W-1:0] scan_start;
  logic [BLK_W-1:0] scan_end;

  logic    lay_start;
  layout_t lay;
  logic    in_acc;
  op_t     in_op;
  logic    out_room;
  logic    word_last;
  logic    chunk_last;

  cbba_layout u_layout (
    .clk           (clk),
    .rst           (rst),
    .start         (lay_start),
    .volume_blocks (volume_blocks),
    .block_bytes   (block_bytes),
    .layout        (lay)
  );

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_blocks <= REG_W'(MAX_BLOCKS);
      block_bytes   <= REG_W'(512);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_VOLUME: volume_blocks <= pwdata[REG_W-1:0];
        REG_BLOCK:  block_bytes   <= pwdata[REG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_VOLUME: prdata = 32'(volume_blocks);
      REG_BLOCK:  prdata = 32'(block_bytes);
      default:    prdata = '0;
    endcase
  end

  // map RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[w_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_word <= map_mem[w_addr];
    end
  end

  // first-fit scan of one 8-bit chunk
  always_comb begin : scan
    logic [CNT_W-1:0]      r;
    logic [BLK_W-1:0]      s;
    logic [BLK_W-1:0]      e;
    logic                  h;
    logic [BLK_W-1:0]      idx;
    logic [CHUNK_BITS-1:0] fr;
    r  = run;
    s  = run_start;
    e  = run_end;
    h  = 1'b0;
    fr = ~rd_word[chunk*CHUNK_BITS +: CHUNK_BITS];
    for (int k = 0; k < CHUNK_BITS; k++) begin
      idx = {w_addr, chunk, SUB_W'(k)};
      if (!h) begin
        if (fr[k]) begin
          if (r == '0) begin
            s = idx;
          end
          r = r + CNT_W'(1);
          if (r == count) begin
            h = 1'b1;
            e = idx;
          end
        end else begin
          r = '0;
        end
      end
    end
    scan_run   = r;
    scan_start = s;
    scan_end   = e;
    scan_hit   = h;
  end

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      fill_word[b] = ({1'b0, w_addr, BIT_W'(b)} < lay.first_blk) ||
                     ({1'b0, w_addr, BIT_W'(b)} >= lay.vol);
      mark_mask[b] = ({w_addr, BIT_W'(b)} >= run_start) &&
                     ({w_addr, BIT_W'(b)} <= run_end);
    end
  end

  assign in_op      = op_t'(s_tuser[0]);
  assign in_acc     = s_tvalid && s_tready;
  assign out_room   = !m_tvalid || m_tready;
  assign word_last  = (w_addr == ADDR_W'(MAP_WORDS - 1));
  assign chunk_last = (chunk == CHUNK_W'(CHUNKS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_op == OP_FORMAT) begin
            state_next = ST_FMT_CALC;
          end else if (!formatted || s_tdata[CNT_W-1:0] == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_FMT_CALC: begin
        if (lay.done) begin
          state_next = lay.fits ? ST_FMT_FILL : ST_DONE;
        end
      end
      ST_FMT_FILL: begin
        if (word_last) begin
          state_next = ST_DONE;
        end
      end
      ST_RD:      state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_hit) begin
          state_next = ST_MARK_RD;
        end else if (chunk_last) begin
          state_next = word_last ? ST_DONE : ST_RD;
        end
      end
      ST_MARK_RD: state_next = ST_MARK_WR;
      ST_MARK_WR: begin
        if (w_addr == run_end[BLK_W-1:BIT_W]) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MARK_RD;
        end
      end
      ST_DONE: begin
        if (out_room) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready  = (state == ST_IDLE);
    lay_start = (state == ST_IDLE) && s_tvalid && (in_op == OP_FORMAT);
    mem_re    = (state == ST_RD) || (state == ST_MARK_RD);
    mem_we    = (state == ST_FMT_FILL) || (state == ST_MARK_WR);
    mem_wdata = (state == ST_FMT_FILL) ? fill_word : (rd_word | mark_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      formatted  <= 1'b0;
      free_count <= '0;
      data_start <= '0;
    end else if (state == ST_FMT_FILL && word_last) begin
      formatted  <= 1'b1;
      free_count <= lay.vol - lay.first_blk;
      data_start <= lay.first_blk;
    end else if (state == ST_MARK_WR && w_addr == run_end[BLK_W-1:BIT_W]) begin
      free_count <= free_count - count;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          count      <= s_tdata[CNT_W-1:0];
          w_addr     <= '0;
          chunk      <= '0;
          run        <= '0;
          res_start  <= '0;
          res_status <= formatted ? STAT_NO_RUN : STAT_UNFORMATTED;
        end
      end
      ST_FMT_CALC: begin
        w_addr     <= '0;
        res_status <= STAT_TOO_SMALL;
      end
      ST_FMT_FILL: begin
        w_addr     <= w_addr + ADDR_W'(1);
        res_status <= STAT_OK;
      end
      ST_SCAN: begin
        run       <= scan_run;
        run_start <= scan_start;
        run_end   <= scan_end;
        chunk     <= chunk + CHUNK_W'(1);
        if (scan_hit) begin
          w_addr <= scan_start[BLK_W-1:BIT_W];
        end else if (chunk_last) begin
          w_addr <= w_addr + ADDR_W'(1);
        end
      end
      ST_MARK_WR: begin
        w_addr     <= w_addr + ADDR_W'(1);
        res_status <= STAT_OK;
        res_start  <= run_start;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_room) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_room) begin
      out_status <= res_status;
      out_start  <= res_start;
      out_free   <= free_count;
      out_first  <= data_start;
    end
  end

  assign m_tdata = {out_first, out_free, out_start, out_status};

`ifndef ASSERT_OFF
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_hit) |->
      (CNT_W'(scan_end) - CNT_W'(scan_start) + CNT_W'(1) == count))
    else $error("found run length differs from request");

  a_unformatted: assert property (@(posedge clk) disable iff (rst)
    !formatted |-> (free_count == '0 && data_start == '0))
    else $error("free count or data start set before format");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(MAX_BLOCKS))
    else $error("free count above map size");

  a_mark_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK_WR) |->
      (w_addr >= run_start[BLK_W-1:BIT_W] && w_addr <= run_end[BLK_W-1:BIT_W]))
    else $error("mark write outside the allocated run");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_room) |=> m_tvalid)
    else $error("finished word not presented");
`endif

endmodule

`default_nettype wire

// File: bench/cbba_alloc_checker.sv
// Checker for the contiguous bitmap block allocator: predicts each result word
// and compares it with the block's output. Depends on cbba_pkg.
`timescale 1ns / 1ps

module cbba_alloc_checker
  import cbba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          outstanding,
  output int          fail_count
);

  // packed in the m_tdata order, lowest field last
  typedef struct packed {
    logic [CNT_W-1:0] first_data;
    logic [CNT_W-1:0] free;
    logic [BLK_W-1:0] start;
    status_t          status;
  } alloc_word_t;

  logic             used_map [MAX_BLOCKS];
  logic             formatted;
  int               free_cnt;
  int               data_start;
  logic [REG_W-1:0] vol_reg;
  logic [REG_W-1:0] bb_reg;
  alloc_word_t      pending_results [$];

  initial fail_count = 0;

  function automatic alloc_word_t format_volume();
    alloc_word_t r;
    int vol;
    int map_bytes;
    int map_blks;
    int first_free_blk;
    r.status = STAT_OK;
    r.start  = '0;
    vol = vol_reg;
    if (vol < MIN_VOLUME || bb_reg < MIN_BLOCK_BYTES) begin
      r.status = STAT_TOO_SMALL;
    end else begin
      if (vol > MAX_BLOCKS) vol = MAX_BLOCKS;
      map_bytes = (vol + 7) / 8;
      map_blks = (map_bytes + int'(bb_reg) - 1) / int'(bb_reg);
      first_free_blk = 1 + map_blks + ROOT_DIR_BLOCKS;
      if (first_free_blk > vol) begin
        r.status = STAT_TOO_SMALL;
      end else begin
        for (int i = 0; i < MAX_BLOCKS; i++)
          used_map[i] = (i < first_free_blk) || (i >= vol);
        free_cnt   = vol - first_free_blk;
        data_start = first_free_blk;
        formatted  = 1'b1;
      end
    end
    r.free       = free_cnt[CNT_W-1:0];
    r.first_data = data_start[CNT_W-1:0];
    return r;
  endfunction

  // first fit over the whole map
  function automatic alloc_word_t allocate_run(int len);
    alloc_word_t r;
    int run;
    int run_start;
    r.status = STAT_NO_RUN;
    r.start  = '0;
    run = 0;
    run_start = 0;
    if (!formatted) begin
      r.status = STAT_UNFORMATTED;
    end else if (len != 0) begin
      for (int i = 0; i < MAX_BLOCKS && r.status != STAT_OK; i++) begin
        if (!used_map[i]) begin
          if (run == 0) run_start = i;
          run++;
          if (run == len) begin
            for (int j = run_start; j < run_start + len; j++) used_map[j] = 1'b1;
            free_cnt -= len;
            r.status = STAT_OK;
            r.start  = run_start[BLK_W-1:0];
          end
        end else begin
          run = 0;
        end
      end
    end
    r.free       = free_cnt[CNT_W-1:0];
    r.first_data = data_start[CNT_W-1:0];
    return r;
  endfunction

  function automatic void flag_mismatch(string field, int want, int got);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fail_count++;
  endfunction

  always @(posedge clk) begin
    alloc_word_t got;
    alloc_word_t want;
    int delta;
    if (rst) begin
      for (int i = 0; i < MAX_BLOCKS; i++) used_map[i] = 1'b1;
      formatted  = 1'b0;
      free_cnt   = 0;
      data_start = 0;
      vol_reg    = REG_W'(4096);
      bb_reg     = REG_W'(512);
      pending_results.delete();
      outstanding <= 0;
    end else begin
      delta = 0;
      if (m_tvalid && m_tready) begin
        got = alloc_word_t'(m_tdata);
        delta--;
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, actual %h",
                   $time, m_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            flag_mismatch("status", want.status, got.status);
          if (got.start !== want.start)
            flag_mismatch("start_block", want.start, got.start);
          if (got.free !== want.free)
            flag_mismatch("free_blocks", want.free, got.free);
          if (got.first_data !== want.first_data)
            flag_mismatch("first_data_block", want.first_data, got.first_data);
        end
      end
      if (s_tvalid && s_tready) begin
        delta++;
        if (op_t'(s_tuser[0]) == OP_FORMAT)
          pending_results.push_back(format_volume());
        else
          pending_results.push_back(allocate_run(int'(s_tdata[12:0])));
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_VOLUME)
          vol_reg = pwdata[REG_W-1:0];
        else
          bb_reg = pwdata[REG_W-1:0];
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

// File: bench/tb_contiguous_bitmap_block_allocator.sv
// Testbench top for the contiguous bitmap block allocator: drives format and
// allocate words and register writes. Depends on cbba_pkg and cbba_alloc_checker.
`timescale 1ns / 1ps

module tb_contiguous_bitmap_block_allocator;
  import cbba_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int ITEM_TARGET  = 800;
  localparam int TAIL_CYCLES  = 700;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [12:0] run_length
  logic [0:0]  s_tuser;   // [0] op
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [1:0] status, [13:2] start_block,
                          // [26:14] free_blocks, [39:27] first_data_block
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int outstanding;
  int fail_count;
  int snd_idle_pct;
  int rcv_stall_pct;
  int items_sent;

  contiguous_bitmap_block_allocator u_top (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cbba_alloc_checker u_chk (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .outstanding, .fail_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial m_tready <= 1'b0;
  always @(posedge clk) m_tready <= ($urandom_range(99) >= rcv_stall_pct);

  task automatic send_word(input op_t op, input int len);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, 13'(len)};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // upper data bits carry noise; the register keeps the low 13
  task automatic write_reg(input logic idx, input int val);
    logic [31:0] word;
    word = $urandom();
    word[REG_W-1:0] = val[REG_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_idle_pct = 88; rcv_stall_pct = 0;  end
      2: begin snd_idle_pct = 0;  rcv_stall_pct = 88; end
      default: begin snd_idle_pct = 6; rcv_stall_pct = 6; end
    endcase
  endtask

  initial begin
    int roll;
    int vol;
    int bb;
    int len;
    int n_items;
    int phase;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst      <= 1'b1;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    items_sent    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // allocate before any format, then fill the default volume exactly
    send_word(OP_ALLOC, 5);
    send_word(OP_ALLOC, 0);
    send_word(OP_FORMAT, 0);
    send_word(OP_ALLOC, 0);
    send_word(OP_ALLOC, 1);
    send_word(OP_ALLOC, 4096);
    send_word(OP_ALLOC, 8191);
    send_word(OP_ALLOC, 4089);
    send_word(OP_ALLOC, 1);
    // bad geometry keeps the earlier format
    drain();
    write_reg(REG_VOLUME, 3);
    send_word(OP_FORMAT, 0);
    send_word(OP_ALLOC, 1);
    // oversized volume, smallest block
    drain();
    write_reg(REG_VOLUME, 8191);
    write_reg(REG_BLOCK, 64);
    send_word(OP_FORMAT, 0);
    send_word(OP_ALLOC, 4083);
    drain();
    write_reg(REG_BLOCK, 63);
    send_word(OP_FORMAT, 0);
    // smallest volume; register change only counts at the next format
    drain();
    write_reg(REG_VOLUME, 8);
    write_reg(REG_BLOCK, 4096);
    send_word(OP_FORMAT, 0);
    send_word(OP_ALLOC, 3);
    send_word(OP_ALLOC, 2);
    drain();
    write_reg(REG_VOLUME, 4096);
    send_word(OP_ALLOC, 1);
    drain();
    write_reg(REG_BLOCK, 8191);
    send_word(OP_FORMAT, 0);
    send_word(OP_ALLOC, 7);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      set_idling(phase % 4);
      phase++;
      roll = $urandom_range(99);
      if (roll < 5)       vol = $urandom_range(7);
      else if (roll < 15) vol = 8;
      else if (roll < 30) vol = 4096;
      else if (roll < 38) vol = $urandom_range(8191, 4097);
      else if (roll < 60) vol = $urandom_range(64, 8);
      else                vol = $urandom_range(4096, 8);
      roll = $urandom_range(99);
      if (roll < 5)       bb = $urandom_range(63);
      else if (roll < 20) bb = 64;
      else if (roll < 30) bb = 4096;
      else if (roll < 35) bb = 8191;
      else if (roll < 60) bb = $urandom_range(512, 64);
      else                bb = $urandom_range(8191, 64);
      write_reg(REG_VOLUME, vol);
      write_reg(REG_BLOCK, bb);
      n_items = $urandom_range(50, 15);
      for (int k = 0; k < n_items; k++) begin
        if (k == 0 ? $urandom_range(9) != 0 : $urandom_range(99) < 8) begin
          send_word(OP_FORMAT, $urandom_range(8191));
        end else begin
          roll = $urandom_range(99);
          if (roll < 70)      len = $urandom_range(16, 1);
          else if (roll < 85) len = $urandom_range(300, 17);
          else if (roll < 90) len = 0;
          else                len = $urandom_range(8191);
          send_word(OP_ALLOC, len);
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
